// ===== sv/c_integer_literal_scanner_assert.svh =====
// Assertion helpers shared by the scanner RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef C_INTEGER_LITERAL_SCANNER_ASSERT_SVH
`define C_INTEGER_LITERAL_SCANNER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CILS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CILS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cils_pkg.sv =====
package cils_pkg;

	// Scan phase, one-hot.
	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_ZERO   = 5'b00010,
		PH_HEXPFX = 5'b00100,
		PH_DIGITS = 5'b01000,
		PH_SUFFIX = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} base_t;

	typedef enum logic [2:0] {
		KIND_INT    = 3'd0,
		KIND_UINT   = 3'd1,
		KIND_LONG   = 3'd2,
		KIND_ULONG  = 3'd3,
		KIND_LLONG  = 3'd4,
		KIND_ULLONG = 3'd5,
		KIND_FLOAT  = 3'd6
	} kind_t;

	localparam int ACC_W = 64;
	localparam int PROD_W = ACC_W + 4;
	localparam int VAL_W = 32;

	// ASCII codes the scanner looks for.
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_F  = 8'h66;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_LO_E  = 8'h65;
	localparam logic [7:0] CH_UP_L  = 8'h4C;
	localparam logic [7:0] CH_LO_L  = 8'h6C;
	localparam logic [7:0] CH_UP_U  = 8'h55;
	localparam logic [7:0] CH_LO_U  = 8'h75;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_X  = 8'h78;

	typedef struct packed {
		logic [7:0] char_code;
		logic       first_byte;
	} lit_t;

	typedef struct packed {
		logic [2:0]       token_kind;
		logic [VAL_W-1:0] value_low;
		logic             too_big;
		logic             hex_digit_missing;
		logic             byte_taken;
	} tok_t;

	// Byte classification handed from the decoder to the control logic.
	typedef struct packed {
		logic       is_zero;
		logic       is_dec;
		logic [3:0] dec_val;
		logic       digit_ok;
		logic [3:0] digit_val;
		logic       is_x;
		logic       is_u;
		logic       is_l;
		logic       is_dot;
		logic       is_e;
	} dec_t;

endpackage

// ===== sv/cils_decode.sv =====
module cils_decode (
	input  logic [7:0]     char_code,
	input  cils_pkg::base_t base,
	output cils_pkg::dec_t  dec
);
	import cils_pkg::*;

	logic is_dec;
	logic is_hex_letter;

	assign is_dec = (char_code >= CH_0) && (char_code <= CH_9);
	assign is_hex_letter = ((char_code >= CH_UP_A) && (char_code <= CH_UP_F)) ||
		((char_code >= CH_LO_A) && (char_code <= CH_LO_F));

	always_comb begin
		dec = '0;
		dec.is_zero = (char_code == CH_0);
		dec.is_dec  = is_dec;
		dec.dec_val = char_code[3:0];
		dec.is_x    = (char_code == CH_LO_X) || (char_code == CH_UP_X);
		dec.is_u    = (char_code == CH_LO_U) || (char_code == CH_UP_U);
		dec.is_l    = (char_code == CH_LO_L) || (char_code == CH_UP_L);
		dec.is_dot  = (char_code == CH_DOT);
		dec.is_e    = (char_code == CH_LO_E) || (char_code == CH_UP_E);
		// Letters A to F sit at codes whose low three bits run from 1 to 6.
		dec.digit_val = is_dec ? char_code[3:0] : 4'(char_code[2:0]) + 4'd9;
		unique case (base)
			BASE_HEX: dec.digit_ok = is_dec || is_hex_letter;
			BASE_OCT: dec.digit_ok = is_dec && !char_code[3];
			default:  dec.digit_ok = is_dec;
		endcase
	end

endmodule

// ===== sv/cils_accum.sv =====
module cils_accum (
	input  logic [cils_pkg::ACC_W-1:0] acc,
	input  logic                       ovf,
	input  cils_pkg::base_t            base,
	input  logic [3:0]                 digit,
	output logic [cils_pkg::ACC_W-1:0] acc_next,
	output logic                       ovf_next
);
	import cils_pkg::*;

	logic [PROD_W-1:0] wide;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] sum;

	assign wide = PROD_W'(acc);

	// Radix multiply as shifts and adds; the top four bits catch any carry past 64 bits.
	always_comb begin
		unique case (base)
			BASE_HEX: prod = wide << 4;
			BASE_OCT: prod = wide << 3;
			default:  prod = (wide << 3) + (wide << 1);
		endcase
	end

	assign sum = prod + PROD_W'(digit);
	assign acc_next = sum[ACC_W-1:0];
	assign ovf_next = ovf || (|sum[PROD_W-1:ACC_W]);

endmodule

// ===== sv/c_integer_literal_scanner.sv =====
// Channel  Direction  Payload         Handshake
// lit      in         cils_pkg::lit_t lit_valid / lit_ready
// tok      out        cils_pkg::tok_t tok_valid / tok_ready
//
// Every source byte is captured in an input register and resolved from there; a byte that
// ends a token writes it into the output register, which then offers it on tok.
// One byte is taken per cycle while no token byte waits on the token register; a single
// 64-bit radix multiply-add lies between the input register and the scan state.
// Reset (arst_n low) returns the scanner to idle and empties both registers.
// A byte that produces a token waits in the input register while the token register
// still holds an untaken token; bytes that produce no token always move on.
module c_integer_literal_scanner (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            lit_valid,
	output logic            lit_ready,
	input  cils_pkg::lit_t  lit,
	output logic            tok_valid,
	input  logic            tok_ready,
	output cils_pkg::tok_t  tok
);
	import cils_pkg::*;

	`include "c_integer_literal_scanner_assert.svh"

	// Input register: one captured request.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       first_s1;

	// Scan state carried from byte to byte.
	phase_t           phase_q;
	base_t            base_q;
	logic [ACC_W-1:0] acc_q;
	logic             ovf_q;
	kind_t            suf_q;

	// Output register.
	logic tok_valid_q;
	tok_t tok_q;

	dec_t             dec;
	logic [ACC_W-1:0] acc_mac;
	logic             ovf_mac;

	phase_t           nx_phase;
	base_t            nx_base;
	logic [ACC_W-1:0] nx_acc;
	logic             nx_ovf;
	kind_t            nx_suf;
	logic             emit;
	logic             use_val;
	logic             run_digits;
	kind_t            r_kind;
	logic             r_missing;
	logic             r_taken;
	tok_t             result;
	logic             proc;

	cils_decode u_decode (
		.char_code(char_s1),
		.base     (base_q),
		.dec      (dec)
	);

	cils_accum u_accum (
		.acc     (acc_q),
		.ovf     (ovf_q),
		.base    (base_q),
		.digit   (dec.digit_val),
		.acc_next(acc_mac),
		.ovf_next(ovf_mac)
	);

	// Next scan state and the token, if any, that the captured byte ends.
	always_comb begin
		nx_phase = phase_q;
		nx_base = base_q;
		nx_acc = acc_q;
		nx_ovf = ovf_q;
		nx_suf = suf_q;
		emit = 1'b0;
		use_val = 1'b0;
		run_digits = 1'b0;
		r_kind = KIND_INT;
		r_missing = 1'b0;
		r_taken = 1'b0;
		if (first_s1) begin
			// A first byte always starts over, dropping any literal in progress.
			nx_base = BASE_DEC;
			nx_acc = '0;
			nx_ovf = 1'b0;
			nx_suf = KIND_INT;
			nx_phase = PH_IDLE;
			priority if (dec.is_zero) begin
				nx_base = BASE_OCT;
				nx_phase = PH_ZERO;
			end else if (dec.is_dec) begin
				nx_acc = ACC_W'(dec.dec_val);
				nx_phase = PH_DIGITS;
			end else if (dec.is_dot) begin
				emit = 1'b1;
				r_kind = KIND_FLOAT;
			end else begin
				// Not a digit at all: an int token of value zero.
				emit = 1'b1;
				r_kind = KIND_INT;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
					nx_phase = PH_IDLE;
				end
				PH_ZERO: begin
					if (dec.is_x) begin
						nx_base = BASE_HEX;
						nx_phase = PH_HEXPFX;
					end else begin
						run_digits = 1'b1;
					end
				end
				PH_HEXPFX: begin
					if (dec.digit_ok) begin
						nx_acc = acc_mac;
						nx_ovf = ovf_mac;
						nx_phase = PH_DIGITS;
					end else begin
						emit = 1'b1;
						r_kind = KIND_INT;
						r_missing = 1'b1;
					end
				end
				PH_DIGITS: begin
					run_digits = 1'b1;
				end
				PH_SUFFIX: begin
					if (dec.is_l) begin
						if (suf_q == KIND_UINT) begin
							nx_suf = KIND_ULONG;
						end else begin
							// Second l closes the literal and is part of it.
							emit = 1'b1;
							use_val = 1'b1;
							r_taken = 1'b1;
							r_kind = (suf_q == KIND_ULONG) ? KIND_ULLONG : KIND_LLONG;
						end
					end else begin
						emit = 1'b1;
						use_val = 1'b1;
						r_kind = suf_q;
					end
				end
				default: begin
					nx_phase = PH_IDLE;
				end
			endcase
			if (run_digits) begin
				nx_phase = PH_DIGITS;
				priority if (dec.digit_ok) begin
					nx_acc = acc_mac;
					nx_ovf = ovf_mac;
				end else if ((base_q != BASE_HEX) && (dec.is_dot || dec.is_e)) begin
					emit = 1'b1;
					r_kind = KIND_FLOAT;
				end else if (dec.is_u) begin
					nx_suf = KIND_UINT;
					nx_phase = PH_SUFFIX;
				end else if (dec.is_l) begin
					nx_suf = KIND_LONG;
					nx_phase = PH_SUFFIX;
				end else begin
					emit = 1'b1;
					use_val = 1'b1;
					r_kind = KIND_INT;
				end
			end
		end
		if (emit) begin
			nx_phase = PH_IDLE;
		end
	end

	always_comb begin
		result.token_kind = r_kind;
		result.value_low = use_val ? acc_q[VAL_W-1:0] : '0;
		result.too_big = use_val && (ovf_q || (|acc_q[ACC_W-1:VAL_W]));
		result.hex_digit_missing = r_missing;
		result.byte_taken = r_taken;
	end

	// The captured byte moves on unless it makes a token and the token register is blocked.
	assign proc = valid_s1 && (!emit || !tok_valid_q || tok_ready);
	assign lit_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (lit_valid && lit_ready) || (valid_s1 && !proc);
		end
	end

	always_ff @(posedge clk) begin
		if (lit_valid && lit_ready) begin
			char_s1 <= lit.char_code;
			first_s1 <= lit.first_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			base_q <= BASE_DEC;
			acc_q <= '0;
			ovf_q <= 1'b0;
			suf_q <= KIND_INT;
		end else if (proc) begin
			phase_q <= nx_phase;
			base_q <= nx_base;
			acc_q <= nx_acc;
			ovf_q <= nx_ovf;
			suf_q <= nx_suf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (proc && emit) begin
			tok_valid_q <= 1'b1;
		end else if (tok_ready) begin
			tok_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			tok_q <= result;
		end
	end

	assign tok_valid = tok_valid_q;
	assign tok = tok_q;

	`CILS_ASSERT_NEXT(a_idle_after_token, proc && emit, phase_q == PH_IDLE,
		"scanner not idle after a token")
	`CILS_ASSERT_SAME(a_missing_is_bare_int, tok_valid_q && tok_q.hex_digit_missing,
		(tok_q.token_kind == KIND_INT) && (tok_q.value_low == '0) && !tok_q.too_big &&
		!tok_q.byte_taken, "bad hex-digit-missing token")
	`CILS_ASSERT_SAME(a_float_no_value, tok_valid_q && (tok_q.token_kind == KIND_FLOAT),
		(tok_q.value_low == '0) && !tok_q.too_big && !tok_q.byte_taken,
		"float handoff carries a value")
	`CILS_ASSERT_SAME(a_taken_is_llong, tok_valid_q && tok_q.byte_taken,
		(tok_q.token_kind == KIND_LLONG) || (tok_q.token_kind == KIND_ULLONG),
		"taken byte on a non long long token")
	`CILS_ASSERT_SAME(a_suffix_kind, phase_q == PH_SUFFIX,
		(suf_q == KIND_UINT) || (suf_q == KIND_LONG) || (suf_q == KIND_ULONG),
		"bad suffix kind in suffix phase")

endmodule
